[rtl/core/mdru_pkg.sv]
// Shared types and constants of the multiply/divide register unit.
`default_nettype none

package mdru_pkg;

  // Register offsets within the window (address minus the window base)
  localparam logic [4:0] OFF_MPY_A   = 5'h02;
  localparam logic [4:0] OFF_MPY_B   = 5'h03;
  localparam logic [4:0] OFF_DIV_LO  = 5'h04;
  localparam logic [4:0] OFF_DIV_HI  = 5'h05;
  localparam logic [4:0] OFF_DIVISOR = 5'h06;
  localparam logic [4:0] OFF_QUO_LO  = 5'h14;
  localparam logic [4:0] OFF_QUO_HI  = 5'h15;
  localparam logic [4:0] OFF_PR_LO   = 5'h16;
  localparam logic [4:0] OFF_PR_HI   = 5'h17;

  // Access kinds
  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // Quotient on a zero divisor
  localparam logic [15:0] DIV_ZERO_QUOTIENT = 16'hFFFF;

  // Iteration counts of the shared shift units
  localparam int unsigned MulSteps = 8;
  localparam int unsigned DivSteps = 16;
  localparam int unsigned CntW     = $clog2(DivSteps);
  localparam logic [CntW-1:0] MulLast = CntW'(MulSteps - 1);
  localparam logic [CntW-1:0] DivLast = CntW'(DivSteps - 1);

  // Kind of work that a captured request calls for
  typedef enum logic [1:0] {
    OP_SIMPLE = 2'd0,
    OP_MUL    = 2'd1,
    OP_DIV    = 2'd2,
    OP_DIVZ   = 2'd3
  } mdru_op_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic wr_reg;
    logic mul_init;
    logic mul_step;
    logic div_init;
    logic div_step;
    logic div_zero;
    logic respond;
  } mdru_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    mdru_op_e op;
  } mdru_sts_t;

endpackage

`default_nettype wire

[rtl/core/mdru_dp.sv]
// Datapath: request latch, operand and result registers, shift-add and shift-subtract units.
`default_nettype none

module mdru_dp import mdru_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       mode_i,
  input  wire logic [4:0] reg_offset_i,
  input  wire logic [7:0] write_data_i,
  input  wire mdru_cmd_t  cmd_i,
  output mdru_sts_t       sts_o,
  output logic [7:0]      read_data_o,
  output logic            mapped_o
);

  logic        mode_q;
  logic [4:0]  off_q;
  logic [7:0]  wdat_q;
  logic [7:0]  mcand_q, mcand_d;
  logic [7:0]  dvd_lo_q, dvd_lo_d;
  logic [7:0]  dvd_hi_q, dvd_hi_d;
  logic [15:0] quo_q, quo_d;
  logic [15:0] pr_q, pr_d;

  logic [8:0]  mul_sum;
  logic [8:0]  div_trial;
  logic [8:0]  div_diff;
  logic        div_fits;
  logic [7:0]  rd_data;
  logic        rd_hit;

  // Hold the request while it is worked on
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= mode_i;
      off_q  <= reg_offset_i;
      wdat_q <= write_data_i;
    end
  end

  // Classify the held request
  always_comb begin
    sts_o.op = OP_SIMPLE;
    if (mode_q == MODE_WRITE) begin
      if (off_q == OFF_MPY_B) begin
        sts_o.op = OP_MUL;
      end else if (off_q == OFF_DIVISOR) begin
        sts_o.op = (wdat_q == 8'h00) ? OP_DIVZ : OP_DIV;
      end
    end
  end

  // One shift-add step: add the multiplicand on the low multiplier bit, shift right
  assign mul_sum = {1'b0, pr_q[15:8]} + {1'b0, (pr_q[0] ? mcand_q : 8'h00)};

  // One restoring step: bring in the next dividend bit, subtract if it fits
  assign div_trial = {pr_q[7:0], quo_q[15]};
  assign div_diff  = div_trial - {1'b0, wdat_q};
  assign div_fits  = div_trial >= {1'b0, wdat_q};

  // Advance the architectural registers
  always_comb begin
    mcand_d  = mcand_q;
    dvd_lo_d = dvd_lo_q;
    dvd_hi_d = dvd_hi_q;
    quo_d    = quo_q;
    pr_d     = pr_q;
    if (cmd_i.wr_reg && mode_q == MODE_WRITE) begin
      case (off_q)
        OFF_MPY_A:  mcand_d  = wdat_q;
        OFF_DIV_LO: dvd_lo_d = wdat_q;
        OFF_DIV_HI: dvd_hi_d = wdat_q;
        default:    ;
      endcase
    end
    if (cmd_i.mul_init) begin
      quo_d = {8'h00, wdat_q};
      pr_d  = {8'h00, wdat_q};
    end
    if (cmd_i.mul_step) begin
      pr_d = {mul_sum, pr_q[7:1]};
    end
    if (cmd_i.div_init) begin
      quo_d = {dvd_hi_q, dvd_lo_q};
      pr_d  = 16'h0000;
    end
    if (cmd_i.div_step) begin
      quo_d = {quo_q[14:0], div_fits};
      pr_d  = {8'h00, (div_fits ? div_diff[7:0] : div_trial[7:0])};
    end
    if (cmd_i.div_zero) begin
      quo_d = DIV_ZERO_QUOTIENT;
      pr_d  = {dvd_hi_q, dvd_lo_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcand_q  <= 8'h00;
      dvd_lo_q <= 8'h00;
      dvd_hi_q <= 8'h00;
      quo_q    <= 16'h0000;
      pr_q     <= 16'h0000;
    end else begin
      mcand_q  <= mcand_d;
      dvd_lo_q <= dvd_lo_d;
      dvd_hi_q <= dvd_hi_d;
      quo_q    <= quo_d;
      pr_q     <= pr_d;
    end
  end

  // Select the read byte of the held request
  always_comb begin
    rd_data = 8'h00;
    rd_hit  = 1'b0;
    if (mode_q == MODE_READ) begin
      case (off_q)
        OFF_QUO_LO: begin rd_data = quo_q[7:0];  rd_hit = 1'b1; end
        OFF_QUO_HI: begin rd_data = quo_q[15:8]; rd_hit = 1'b1; end
        OFF_PR_LO:  begin rd_data = pr_q[7:0];   rd_hit = 1'b1; end
        OFF_PR_HI:  begin rd_data = pr_q[15:8];  rd_hit = 1'b1; end
        default:    ;
      endcase
    end
  end

  // Drive the result only in the response cycle
  assign read_data_o = cmd_i.respond ? rd_data : 8'h00;
  assign mapped_o    = cmd_i.respond & rd_hit;

endmodule

`default_nettype wire

[rtl/core/mdru_ctrl.sv]
// Controller: sequences capture, decode, iteration and response of each request.
`default_nettype none

module mdru_ctrl import mdru_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      start_i,
  input  wire mdru_sts_t sts_i,
  output mdru_cmd_t      cmd_o,
  output logic           busy_o,
  output logic           done_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DECODE = 5'b00010,
    ST_MUL    = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_RESP   = 5'b10000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  // Next state, step count and datapath commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_DECODE;
        end
      end
      ST_DECODE: begin
        cnt_d = '0;
        case (sts_i.op)
          OP_MUL: begin
            cmd_o.mul_init = 1'b1;
            state_d        = ST_MUL;
          end
          OP_DIV: begin
            cmd_o.div_init = 1'b1;
            state_d        = ST_DIV;
          end
          OP_DIVZ: begin
            cmd_o.div_zero = 1'b1;
            state_d        = ST_RESP;
          end
          default: begin
            cmd_o.wr_reg = 1'b1;
            state_d      = ST_RESP;
          end
        endcase
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == MulLast) begin
          state_d = ST_RESP;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == DivLast) begin
          state_d = ST_RESP;
        end
      end
      ST_RESP: begin
        cmd_o.respond = 1'b1;
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = (state_q == ST_RESP);

endmodule

`default_nettype wire

[rtl/core/multiply_divide_register_unit_top.sv]
// Top level of the register-mapped 8x8 multiply and 16/8 divide unit.
//
//  Channel   Handshake              Payload
//  request   start & !busy          mode_i, reg_offset_i, write_data_i
//  result    done_o (one cycle)     read_data_o, mapped_o
//
// A read or a plain register write goes from the accepting cycle through decode to the strobe.
// A multiplier write adds 8 shift-add steps of the shared 8-bit adder after decode.
// A divisor write adds 16 restoring steps of the 9-bit subtractor after decode;
// a zero divisor skips the steps.
// Reset clears all operand and result registers; busy stays high through the strobe.
// The result is shown for one cycle only and cannot be held off.
`default_nettype none

module multiply_divide_register_unit_top import mdru_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic       mode_i,
  input  wire logic [4:0] reg_offset_i,
  input  wire logic [7:0] write_data_i,
  output logic            done_o,
  output logic [7:0]      read_data_o,
  output logic            mapped_o
);

  mdru_cmd_t cmd;
  mdru_sts_t sts;

  mdru_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  mdru_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (mode_i),
    .reg_offset_i (reg_offset_i),
    .write_data_i (write_data_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .read_data_o  (read_data_o),
    .mapped_o     (mapped_o)
  );

endmodule

`default_nettype wire

[dv/tb.sv]
// Self-checking testbench of the register-mapped multiply/divide unit.
`timescale 1ns / 100ps

module tb;
  import mdru_pkg::*;

  localparam int unsigned ITEMS      = 1050;
  localparam int unsigned CYCLE_CAP  = 300000;
  localparam int unsigned TAIL_WAIT  = 25;
  localparam logic [4:0]  OFF_FIRST  = 5'h00;
  localparam logic [4:0]  OFF_LAST   = 5'h1F;

  typedef struct packed {
    logic [7:0] rd_data;
    logic       hit;
  } bus_resp_t;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  logic       mode_i;
  logic [4:0] reg_offset_i;
  logic [7:0] write_data_i;
  logic       done_o;
  logic [7:0] read_data_o;
  logic       mapped_o;

  // Mirror of the unit's registers
  logic [7:0]  mcand_r;
  logic [7:0]  div_lo_r;
  logic [7:0]  div_hi_r;
  logic [15:0] quo_r;
  logic [15:0] prod_rem_r;

  bus_resp_t   owed_resp_q[$];
  int unsigned err_cnt;
  int unsigned useful_cnt;
  int unsigned cycle_cnt;
  int unsigned burst_left;
  bit          req_held;
  bit          pace_off;

  multiply_divide_register_unit_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .mode_i      (mode_i),
    .reg_offset_i(reg_offset_i),
    .write_data_i(write_data_i),
    .done_o      (done_o),
    .read_data_o (read_data_o),
    .mapped_o    (mapped_o)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Apply one bus access to the mirror and return the response it owes
  function automatic bus_resp_t reg_access(input logic mode, input logic [4:0] off,
                                           input logic [7:0] data);
    bus_resp_t   resp;
    logic [15:0] dvd;
    resp = '0;
    dvd  = {div_hi_r, div_lo_r};
    if (mode == MODE_WRITE) begin
      case (off)
        OFF_MPY_A: mcand_r = data;
        OFF_MPY_B: begin
          prod_rem_r = 16'(mcand_r) * 16'(data);
          quo_r      = 16'(data);
        end
        OFF_DIV_LO: div_lo_r = data;
        OFF_DIV_HI: div_hi_r = data;
        OFF_DIVISOR: begin
          if (data == '0) begin
            quo_r      = DIV_ZERO_QUOTIENT;
            prod_rem_r = dvd;
          end else begin
            quo_r      = dvd / 16'(data);
            prod_rem_r = dvd % 16'(data);
          end
        end
        default: ;
      endcase
    end else begin
      resp.hit = 1'b1;
      case (off)
        OFF_QUO_LO: resp.rd_data = quo_r[7:0];
        OFF_QUO_HI: resp.rd_data = quo_r[15:8];
        OFF_PR_LO:  resp.rd_data = prod_rem_r[7:0];
        OFF_PR_HI:  resp.rd_data = prod_rem_r[15:8];
        default:    resp.hit = 1'b0;
      endcase
    end
    return resp;
  endfunction

  // Byte with a lean towards the edges of its range
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h01;
      3:       return 8'h80;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [4:0] pick_result_off();
    case ($urandom_range(0, 3))
      0:       return OFF_QUO_LO;
      1:       return OFF_QUO_HI;
      2:       return OFF_PR_LO;
      default: return OFF_PR_HI;
    endcase
  endfunction

  // Drop start, unless it is already low
  task automatic lower_start();
    if (req_held) begin
      start    <= 1'b0;
      req_held = 1'b0;
    end
  endtask

  // Space requests into bursts with random gaps between them
  task automatic pace();
    int unsigned gap;
    if (pace_off) return;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 24);
      if (gap > 0) begin
        lower_start();
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(0, 12);
    end
  endtask

  // Present one request and hold it until the unit takes it
  task automatic send_req(input logic mode, input logic [4:0] off, input logic [7:0] data);
    start        <= 1'b1;
    mode_i       <= mode;
    reg_offset_i <= off;
    write_data_i <= data;
    req_held     = 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    owed_resp_q = {owed_resp_q, reg_access(mode, off, data)};
    if (mode == MODE_READ || off inside {OFF_MPY_A, OFF_MPY_B, OFF_DIV_LO, OFF_DIV_HI,
                                         OFF_DIVISOR})
      useful_cnt++;
    pace();
  endtask

  // Hold off until every owed response has come back
  task automatic drain_requests();
    lower_start();
    while (owed_resp_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic test_reset_values();
    send_req(MODE_READ, OFF_QUO_LO, 8'hFF);
    send_req(MODE_READ, OFF_QUO_HI, 8'hFF);
    send_req(MODE_READ, OFF_PR_LO, 8'hFF);
    send_req(MODE_READ, OFF_PR_HI, 8'hFF);
  endtask

  task automatic test_multiply_extremes();
    send_req(MODE_WRITE, OFF_MPY_A, 8'hFF);
    send_req(MODE_WRITE, OFF_MPY_B, 8'hFF);
    send_req(MODE_READ, OFF_PR_LO, 8'h00);
    send_req(MODE_READ, OFF_PR_HI, 8'h00);
    send_req(MODE_READ, OFF_QUO_LO, 8'h00);
    send_req(MODE_READ, OFF_QUO_HI, 8'h00);
    // Zero multiplier clears the product
    send_req(MODE_WRITE, OFF_MPY_B, 8'h00);
    send_req(MODE_READ, OFF_PR_HI, 8'h00);
  endtask

  task automatic test_divide_cases();
    send_req(MODE_WRITE, OFF_DIV_LO, 8'hFF);
    send_req(MODE_WRITE, OFF_DIV_HI, 8'hFF);
    send_req(MODE_WRITE, OFF_DIVISOR, 8'hFF);
    send_req(MODE_READ, OFF_QUO_HI, 8'h00);
    // Zero divisor: all-ones quotient, dividend left as remainder
    send_req(MODE_WRITE, OFF_DIVISOR, 8'h00);
    send_req(MODE_READ, OFF_QUO_LO, 8'h00);
    send_req(MODE_READ, OFF_PR_HI, 8'h00);
  endtask

  task automatic test_unmapped_access();
    send_req(MODE_READ, OFF_FIRST, 8'hFF);
    send_req(MODE_READ, OFF_LAST, 8'hFF);
    send_req(MODE_READ, OFF_MPY_A, 8'h00);
    // Writes to result registers and to holes leave the state alone
    send_req(MODE_WRITE, OFF_QUO_LO, 8'hA5);
    send_req(MODE_WRITE, OFF_LAST, 8'h5A);
    send_req(MODE_READ, OFF_QUO_LO, 8'h00);
  endtask

  task automatic test_drain_pause();
    send_req(MODE_WRITE, OFF_DIV_HI, 8'h12);
    send_req(MODE_WRITE, OFF_DIVISOR, 8'h07);
    drain_requests();
    send_req(MODE_READ, OFF_PR_LO, 8'h00);
  endtask

  task automatic test_random_sequences();
    int unsigned kind;
    int unsigned n_reads;
    int unsigned seq_cnt;
    seq_cnt = 0;
    while (useful_cnt < ITEMS) begin
      // Run some stretches with no gaps at all
      if (seq_cnt % 60 == 0) pace_off = ($urandom_range(0, 3) == 0);
      if (seq_cnt % 97 == 96) drain_requests();
      kind    = $urandom_range(0, 9);
      n_reads = $urandom_range(1, 4);
      if (kind < 4) begin
        if ($urandom_range(0, 4) != 0) send_req(MODE_WRITE, OFF_MPY_A, rand_byte());
        send_req(MODE_WRITE, OFF_MPY_B, rand_byte());
      end else if (kind < 8) begin
        if ($urandom_range(0, 4) != 0) send_req(MODE_WRITE, OFF_DIV_LO, rand_byte());
        if ($urandom_range(0, 4) != 0) send_req(MODE_WRITE, OFF_DIV_HI, rand_byte());
        send_req(MODE_WRITE, OFF_DIVISOR,
                 ($urandom_range(0, 7) == 0) ? 8'h00 : rand_byte());
      end else begin
        n_reads = 0;
        repeat ($urandom_range(1, 4))
          send_req(logic'($urandom_range(0, 1)), 5'($urandom_range(0, 31)), 8'($urandom));
      end
      repeat (n_reads) send_req(MODE_READ, pick_result_off(), 8'($urandom));
      seq_cnt++;
    end
  endtask

  // Compare each response strobe with the oldest one owed
  always @(posedge clk_i) begin
    bus_resp_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (owed_resp_q.size() == 0) begin
        $display("%0t: response with none owed: read_data %h mapped %b",
                 $time, read_data_o, mapped_o);
        err_cnt++;
      end else begin
        want = owed_resp_q.pop_front();
        if (read_data_o !== want.rd_data) begin
          $display("%0t: read_data expected %h actual %h", $time, want.rd_data, read_data_o);
          err_cnt++;
        end
        if (mapped_o !== want.hit) begin
          $display("%0t: mapped expected %b actual %b", $time, want.hit, mapped_o);
          err_cnt++;
        end
      end
    end
  end

  // Guard against a hung unit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_CAP) begin
      $display("FAIL multiply_divide_register_unit_top");
      $finish;
    end
  end

  initial begin
    mcand_r      = '0;
    div_lo_r     = '0;
    div_hi_r     = '0;
    quo_r        = '0;
    prod_rem_r   = '0;
    err_cnt      = 0;
    useful_cnt   = 0;
    cycle_cnt    = 0;
    burst_left   = 0;
    req_held     = 1'b0;
    pace_off     = 1'b0;
    rst_ni       <= 1'b0;
    start        <= 1'b0;
    mode_i       <= MODE_READ;
    reg_offset_i <= OFF_FIRST;
    write_data_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_multiply_extremes();
    test_divide_cases();
    test_unmapped_access();
    test_drain_pause();
    test_random_sequences();

    lower_start();
    while (owed_resp_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_WAIT) @(posedge clk_i);
    if (err_cnt == 0 && owed_resp_q.size() == 0) begin
      $display("PASS multiply_divide_register_unit_top");
    end else begin
      $display("FAIL multiply_divide_register_unit_top");
    end
    $finish;
  end

endmodule
